>>> design/box_filter_moving_average_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the box filter
// Concurrent checks on posedge clk; BFMA_ASSERT is off while rst is high.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_MOVING_AVERAGE_ASSERT_SVH
`define BOX_FILTER_MOVING_AVERAGE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BFMA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("box filter assertion failed");
`define BFMA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("box filter assertion failed");
`else
`define BFMA_ASSERT(lbl, prop)
`define BFMA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> design/bfma_pkg.sv
// ----------------------------------------------------------------------------
// bfma_pkg
// Shared types and constants of the box filter.
// ----------------------------------------------------------------------------
package bfma_pkg;

  localparam int KERNEL_W = 4;
  localparam int DIM_W    = 11;
  localparam int PIX_W    = 8;
  localparam int SUM_W    = 16;
  localparam int CIDX_W   = 2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_KERNEL = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [KERNEL_W-1:0] KERNEL_RST = 4'd3;
  localparam logic [DIM_W-1:0]    WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RST = 11'd480;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SUM   = 6'b000010,
    ST_FLUSH = 6'b000100,
    ST_LAST  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

endpackage

>>> design/bfma_ram.sv
// ----------------------------------------------------------------------------
// bfma_ram
// Line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfma_ram #(
  parameter int DEPTH = 14351,
  parameter int DW    = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/bfma_div.sv
// ----------------------------------------------------------------------------
// bfma_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfma_div
  import bfma_pkg::*;
#(
  parameter int N = 16,
  parameter int D = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CNT_W = $clog2(N + 1);

  logic [CNT_W-1:0] cnt;
  logic [D-1:0]     rem;
  logic [D:0]       shifted;

  assign shifted = {rem, quotient[N-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt      <= CNT_W'(N);
        rem      <= '0;
        quotient <= dividend;
      end else if (cnt != '0) begin
        if (shifted >= {1'b0, divisor}) begin
          rem      <= D'(shifted - {1'b0, divisor});
          quotient <= {quotient[N-2:0], 1'b1};
        end else begin
          rem      <= shifted[D-1:0];
          quotient <= {quotient[N-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/box_filter_moving_average.sv
// ----------------------------------------------------------------------------
// box_filter_moving_average
// k-by-k box blur over a raster stream of grayscale pixels.
//
// Input channel (in_valid/in_ready, op, pixel): one pixel per transfer in
// raster order, then flush transfers (op = 1) that drain the pending outputs.
// Output channel (out_valid/out_ready, average, frame_end): one average per
// frame pixel, frame_end marks the last one of the frame.
// Output j is produced by the input transfer of pixel j + h*width + h
// (h = k/2), or by a flush transfer once the whole frame is in.
// An item producing a result goes through the accept, k*k line store reads
// (one read port), the ST_FLUSH and ST_LAST read pipeline states, the
// bit-serial divider and the output state; an item without a result is done
// once it is accepted.
// A finished result waits in the output register; the next item is taken
// meanwhile, but a new result waits until the receiver takes the old one.
// Reset and every write to the kernel, width or height setting restart the
// frame; the input side is held off after either while derived sizes settle.
// ----------------------------------------------------------------------------
`include "box_filter_moving_average_assert.svh"

module box_filter_moving_average
  import bfma_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_KERNEL = 15
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [DIM_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic [PIX_W-1:0]    pixel,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PIX_W-1:0]    average,
  output logic                frame_end
);

  localparam int RING = (MAX_KERNEL - 1) * MAX_WIDTH + MAX_KERNEL;
  localparam int AW   = $clog2(RING);
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 1);
  localparam int FW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int PW   = ((CW > RW) ? CW : RW) + 2;
  localparam int KMAX = (MAX_KERNEL - 1) | 1;

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(RING)) begin
      s = s - (AW+1)'(RING);
    end
    return s[AW-1:0];
  endfunction

  state_t state;

  logic [KERNEL_W-1:0] cfg_k;
  logic [DIM_W-1:0]    cfg_w;
  logic [DIM_W-1:0]    cfg_h;
  logic [1:0]          pend;

  logic [KERNEL_W-1:0] k_c, hk_c;
  logic [CW-1:0]       w_c;
  logic [RW-1:0]       ht_c;
  logic [FW-1:0]       delay_c, frame_c;
  logic [AW-1:0]       ring_start_c, row_step_c;
  logic [31:0]         step_tmp;

  logic [KERNEL_W-1:0] k_r, hk_r;
  logic [PIX_W-1:0]    kk_r;
  logic [CW-1:0]       w_r;
  logic [RW-1:0]       ht_r;
  logic [FW-1:0]       delay_r, frame_r;
  logic [AW-1:0]       ring_start_r, row_step_r;

  logic [RW-1:0] in_row, out_row;
  logic [CW-1:0] in_col, out_col;
  logic [FW-1:0] in_pos, out_idx;
  logic [AW-1:0] wr_addr, rd_base, rd_addr;

  logic signed [PW-1:0] rr, cc;
  logic [KERNEL_W-1:0]  dr, dc;
  logic                 rd_valid_q, rd_in_q;
  logic [SUM_W-1:0]     sum;
  logic [PIX_W-1:0]     rdata;

  logic             accept, draining, below, mem_we, inframe, last_out;
  logic             cfg_hit;
  logic             div_done;
  logic [SUM_W-1:0] quo;

  always_comb begin
    k_c = cfg_k[0] ? cfg_k : KERNEL_W'(cfg_k + 1'b1);
    if (32'(k_c) > KMAX) begin
      k_c = KERNEL_W'(KMAX);
    end
    hk_c = k_c >> 1;
    if (cfg_w == '0) begin
      w_c = CW'(1);
    end else if (32'(cfg_w) > MAX_WIDTH) begin
      w_c = CW'(MAX_WIDTH);
    end else begin
      w_c = CW'(cfg_w);
    end
    if (cfg_h == '0) begin
      ht_c = RW'(1);
    end else if (32'(cfg_h) > MAX_HEIGHT) begin
      ht_c = RW'(MAX_HEIGHT);
    end else begin
      ht_c = RW'(cfg_h);
    end
    delay_c      = FW'(32'(hk_c) * 32'(w_c) + 32'(hk_c));
    frame_c      = FW'(32'(w_c) * 32'(ht_c));
    ring_start_c = (delay_c == '0) ? '0 : AW'(32'(RING) - 32'(delay_c));
    step_tmp     = 32'(w_c) + 32'(RING) + 32'd1 - 32'(k_c);
    if (step_tmp >= 32'(RING)) begin
      step_tmp = step_tmp - 32'(RING);
    end
    row_step_c = AW'(step_tmp);
  end

  always_ff @(posedge clk) begin
    k_r          <= k_c;
    hk_r         <= hk_c;
    kk_r         <= PIX_W'(32'(k_c) * 32'(k_c));
    w_r          <= w_c;
    ht_r         <= ht_c;
    delay_r      <= delay_c;
    frame_r      <= frame_c;
    ring_start_r <= ring_start_c;
    row_step_r   <= row_step_c;
  end

  assign in_ready = (state == ST_IDLE) && (pend == 2'd0);
  assign accept   = in_valid && in_ready;
  assign draining = (in_row >= ht_r);
  assign below    = {1'b0, in_pos} < ((FW+1)'(delay_r) + (FW+1)'(out_idx));
  assign mem_we   = accept && !draining && (op == OP_PIXEL);
  assign inframe  = (rr >= 0) && (rr < $signed(PW'(ht_r)))
                 && (cc >= 0) && (cc < $signed(PW'(w_r)));
  assign last_out = ((out_idx + 1'b1) == frame_r);
  assign cfg_hit  = cfg_write && (cfg_index == CFG_KERNEL || cfg_index == CFG_WIDTH ||
                                  cfg_index == CFG_HEIGHT);

  bfma_ram #(.DEPTH(RING), .DW(PIX_W), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (pixel),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  bfma_div #(.N(SUM_W), .D(PIX_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_LAST),
    .dividend (sum),
    .divisor  (kk_r),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend       <= 2'd2;
      cfg_k      <= KERNEL_RST;
      cfg_w      <= WIDTH_RST;
      cfg_h      <= HEIGHT_RST;
      in_row     <= '0;
      in_col     <= '0;
      in_pos     <= '0;
      out_row    <= '0;
      out_col    <= '0;
      out_idx    <= '0;
      wr_addr    <= '0;
      rd_base    <= '0;
      rd_valid_q <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_valid_q <= (state == ST_SUM);
      if (rd_valid_q && rd_in_q) begin
        sum <= sum + SUM_W'(rdata);
      end
      if (out_valid && out_ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      if ((pend != 2'd0) && !cfg_hit) begin
        pend <= pend - 1'b1;
        if (pend == 2'd1) begin
          rd_base <= ring_start_r;
        end
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!draining) begin
              if (op == OP_PIXEL) begin
                wr_addr <= ring_add(wr_addr, AW'(1));
                in_pos  <= in_pos + 1'b1;
                if ((in_col + 1'b1) >= w_r) begin
                  in_col <= '0;
                  in_row <= in_row + 1'b1;
                end else begin
                  in_col <= in_col + 1'b1;
                end
                if (!below) begin
                  rr      <= $signed(PW'(out_row)) - $signed(PW'(hk_r));
                  cc      <= $signed(PW'(out_col)) - $signed(PW'(hk_r));
                  dr      <= '0;
                  dc      <= '0;
                  rd_addr <= rd_base;
                  sum     <= '0;
                  state   <= ST_SUM;
                end
              end
            end else if (out_idx >= frame_r) begin
              in_row  <= '0;
              in_col  <= '0;
              in_pos  <= '0;
              out_row <= '0;
              out_col <= '0;
              out_idx <= '0;
              wr_addr <= '0;
              rd_base <= ring_start_r;
            end else begin
              rr      <= $signed(PW'(out_row)) - $signed(PW'(hk_r));
              cc      <= $signed(PW'(out_col)) - $signed(PW'(hk_r));
              dr      <= '0;
              dc      <= '0;
              rd_addr <= rd_base;
              sum     <= '0;
              state   <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          rd_in_q <= inframe;
          if (dc == k_r - 1'b1) begin
            dc      <= '0;
            cc      <= $signed(PW'(out_col)) - $signed(PW'(hk_r));
            rr      <= rr + 1'b1;
            rd_addr <= ring_add(rd_addr, row_step_r);
            if (dr == k_r - 1'b1) begin
              state <= ST_FLUSH;
            end else begin
              dr <= dr + 1'b1;
            end
          end else begin
            dc      <= dc + 1'b1;
            cc      <= cc + 1'b1;
            rd_addr <= ring_add(rd_addr, AW'(1));
          end
        end
        ST_FLUSH: begin
          state <= ST_LAST;
        end
        ST_LAST: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            average   <= quo[PIX_W-1:0];
            frame_end <= last_out;
            state     <= ST_IDLE;
            if (last_out) begin
              in_row  <= '0;
              in_col  <= '0;
              in_pos  <= '0;
              out_row <= '0;
              out_col <= '0;
              out_idx <= '0;
              wr_addr <= '0;
              rd_base <= ring_start_r;
            end else begin
              out_idx <= out_idx + 1'b1;
              rd_base <= ring_add(rd_base, AW'(1));
              if ((out_col + 1'b1) >= w_r) begin
                out_col <= '0;
                out_row <= out_row + 1'b1;
              end else begin
                out_col <= out_col + 1'b1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (cfg_hit) begin
        case (cfg_index)
          CFG_KERNEL: cfg_k <= cfg_data[KERNEL_W-1:0];
          CFG_WIDTH:  cfg_w <= cfg_data;
          CFG_HEIGHT: cfg_h <= cfg_data;
          default:    cfg_k <= cfg_k;
        endcase
        pend    <= 2'd2;
        in_row  <= '0;
        in_col  <= '0;
        in_pos  <= '0;
        out_row <= '0;
        out_col <= '0;
        out_idx <= '0;
        wr_addr <= '0;
      end
    end
  end

  `BFMA_ASSERT(a_div_in_div, div_done |-> state == ST_DIV)
  `BFMA_ASSERT(a_sum_bound, (state == ST_LAST) |-> (32'(sum) <= 32'(kk_r) * 255))
  `BFMA_ASSERT(a_rd_base_range, (pend == 2'd0) |-> (32'(rd_base) < RING))
  `BFMA_ASSERT(a_out_idx_range, (pend == 2'd0) |-> (out_idx < frame_r))

endmodule
